>>> design/rsbd_pkg.sv
// Shared types and register indexes for the RLE sprite blit decoder.
package rsbd_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_WIDTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_HEIGHT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_PITCH      = 3'd5;

  localparam int unsigned CFG_DATA_W = 12;

  // Register file contents
  typedef struct packed {
    logic [7:0]  origin_x;
    logic [7:0]  origin_y;
    logic [7:0]  run_width;
    logic [7:0]  run_height;
    logic [2:0]  bytes_per_pixel;
    logic [11:0] dest_pitch;
  } cfg_t;

  // Per-result flags
  typedef struct packed {
    logic write_valid;
    logic sprite_done;
    logic format_error;
  } flags_t;

  // Stream decode phase
  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_OPAQUE = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

endpackage

>>> design/rsbd_decode.sv
// Run-length stream decode state and per-byte step logic.
module rsbd_decode #(
  parameter int ADDR_BITS           = 20,
  parameter int MAX_BYTES_PER_PIXEL = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsbd_pkg::cfg_t        cfg,
  input  logic                  step_en,
  input  logic [7:0]            code_byte,
  output logic                  res_valid,
  output rsbd_pkg::flags_t      res_flags,
  output logic [ADDR_BITS-1:0]  res_addr,
  output logic [7:0]            res_byte
);

  localparam int BPP_W   = $clog2(MAX_BYTES_PER_PIXEL + 1);
  localparam int CNT_W   = $clog2(255 * MAX_BYTES_PER_PIXEL + 1);
  localparam int COL_W   = 9;
  localparam int START_W = 21;

  rsbd_pkg::phase_t      phase_r, phase_nxt;
  logic [COL_W-1:0]      column_r, column_nxt;
  logic [7:0]            rows_r, rows_nxt;
  logic [ADDR_BITS-1:0]  row_base_r, row_base_nxt;
  logic [CNT_W-1:0]      copy_left_r, copy_left_nxt;
  logic [ADDR_BITS-1:0]  waddr_r, waddr_nxt;
  logic                  active_r, active_nxt;

  logic [BPP_W-1:0]           bpp;
  logic [COL_W:0]             col_sum;
  logic                       overshoot;
  logic [COL_W:0]             start_over;
  logic [19:0]                start_y;
  logic [7+BPP_W:0]           start_x;
  logic [START_W-1:0]         start_sum;
  logic [ADDR_BITS+START_W-1:0] start_ext;
  logic [COL_W+BPP_W-1:0]     col_off;
  logic [7+BPP_W:0]           copy_prod;
  logic [CNT_W-1:0]           copy_dec;
  logic                       at_row_end;
  logic [7:0]                 rows_dec;

  // Effective bytes per pixel: zero acts as one, clamp at the maximum
  always_comb begin
    if (cfg.bytes_per_pixel == 3'd0) begin
      bpp = BPP_W'(1);
    end else if (32'(cfg.bytes_per_pixel) > 32'(MAX_BYTES_PER_PIXEL)) begin
      bpp = BPP_W'(MAX_BYTES_PER_PIXEL);
    end else begin
      bpp = BPP_W'(cfg.bytes_per_pixel);
    end
  end

  // Sprite origin address
  assign start_y   = 20'(cfg.origin_y) * 20'(cfg.dest_pitch);
  assign start_x   = (8+BPP_W)'(cfg.origin_x) * (8+BPP_W)'(bpp);
  assign start_sum = START_W'(start_y) + START_W'(start_x);
  assign start_ext = {{ADDR_BITS{1'b0}}, start_sum};

  // Column arithmetic shared by the count phases
  assign col_sum    = (COL_W+1)'(column_r) + (COL_W+1)'(code_byte);
  assign overshoot  = col_sum > (COL_W+1)'(cfg.run_width);
  assign start_over = (COL_W+1)'(code_byte);
  assign col_off    = (COL_W+BPP_W)'(column_r) * (COL_W+BPP_W)'(bpp);
  assign copy_prod  = (8+BPP_W)'(code_byte) * (8+BPP_W)'(bpp);
  assign copy_dec   = (copy_left_r != '0) ? copy_left_r - CNT_W'(1) : '0;
  assign at_row_end = column_r == COL_W'(cfg.run_width);
  assign rows_dec   = rows_r - 8'd1;

  // One step of the decoder per accepted beat
  always_comb begin
    phase_nxt     = phase_r;
    column_nxt    = column_r;
    rows_nxt      = rows_r;
    row_base_nxt  = row_base_r;
    copy_left_nxt = copy_left_r;
    waddr_nxt     = waddr_r;
    active_nxt    = active_r;
    res_valid     = 1'b0;
    res_flags     = '0;
    res_addr      = '0;
    res_byte      = '0;

    if (!active_r) begin
      // Sprite start; this byte is the first skip count
      rows_nxt      = (cfg.run_height == 8'd0) ? 8'd1 : cfg.run_height;
      row_base_nxt  = start_ext[ADDR_BITS-1:0];
      copy_left_nxt = '0;
      waddr_nxt     = '0;
      phase_nxt     = rsbd_pkg::PH_SKIP;
      column_nxt    = '0;
      if (start_over > (COL_W+1)'(cfg.run_width)) begin
        res_valid              = 1'b1;
        res_flags.sprite_done  = 1'b1;
        res_flags.format_error = 1'b1;
      end else begin
        active_nxt = 1'b1;
        column_nxt = COL_W'(code_byte);
        phase_nxt  = rsbd_pkg::PH_OPAQUE;
      end
    end else begin
      case (phase_r)
        rsbd_pkg::PH_DATA: begin
          res_valid             = 1'b1;
          res_flags.write_valid = 1'b1;
          res_addr              = waddr_r;
          res_byte              = code_byte;
          waddr_nxt             = waddr_r + ADDR_BITS'(1);
          copy_left_nxt         = copy_dec;
          if (copy_dec == '0) begin
            phase_nxt = rsbd_pkg::PH_SKIP;
            if (at_row_end) begin
              rows_nxt = rows_dec;
              if (rows_dec == 8'd0) begin
                active_nxt            = 1'b0;
                copy_left_nxt         = '0;
                res_flags.sprite_done = 1'b1;
              end else begin
                column_nxt   = '0;
                row_base_nxt = row_base_r + ADDR_BITS'(cfg.dest_pitch);
              end
            end
          end
        end
        rsbd_pkg::PH_OPAQUE: begin
          if (overshoot) begin
            active_nxt             = 1'b0;
            phase_nxt              = rsbd_pkg::PH_SKIP;
            copy_left_nxt          = '0;
            res_valid              = 1'b1;
            res_flags.sprite_done  = 1'b1;
            res_flags.format_error = 1'b1;
          end else if (code_byte != 8'd0) begin
            waddr_nxt     = row_base_r + ADDR_BITS'(col_off);
            copy_left_nxt = CNT_W'(copy_prod);
            column_nxt    = col_sum[COL_W-1:0];
            phase_nxt     = rsbd_pkg::PH_DATA;
          end else if (column_r == '0) begin
            // Zero pair at the start of a row ends the sprite
            active_nxt            = 1'b0;
            phase_nxt             = rsbd_pkg::PH_SKIP;
            copy_left_nxt         = '0;
            res_valid             = 1'b1;
            res_flags.sprite_done = 1'b1;
          end else begin
            phase_nxt = rsbd_pkg::PH_SKIP;
            if (at_row_end) begin
              rows_nxt = rows_dec;
              if (rows_dec == 8'd0) begin
                active_nxt            = 1'b0;
                copy_left_nxt         = '0;
                res_valid             = 1'b1;
                res_flags.sprite_done = 1'b1;
              end else begin
                column_nxt   = '0;
                row_base_nxt = row_base_r + ADDR_BITS'(cfg.dest_pitch);
              end
            end
          end
        end
        default: begin
          // Skip count
          if (overshoot) begin
            active_nxt             = 1'b0;
            phase_nxt              = rsbd_pkg::PH_SKIP;
            copy_left_nxt          = '0;
            res_valid              = 1'b1;
            res_flags.sprite_done  = 1'b1;
            res_flags.format_error = 1'b1;
          end else begin
            column_nxt = col_sum[COL_W-1:0];
            phase_nxt  = rsbd_pkg::PH_OPAQUE;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rsbd_pkg::PH_SKIP;
      column_r    <= '0;
      rows_r      <= '0;
      row_base_r  <= '0;
      copy_left_r <= '0;
      waddr_r     <= '0;
      active_r    <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      column_r    <= column_nxt;
      rows_r      <= rows_nxt;
      row_base_r  <= row_base_nxt;
      copy_left_r <= copy_left_nxt;
      waddr_r     <= waddr_nxt;
      active_r    <= active_nxt;
    end
  end

endmodule

>>> design/rle_sprite_blit_decoder.sv
// Top level: config registers, decode step and registered result beat.
// Each result is registered and appears in the cycle after the beat that causes it.
// Throughput: one input beat per cycle unless out_ready stalls it; the single
// output register after the decode step refills on the same edge it drains.
// Reset: synchronous active-low rst_n clears decode state and the output
// valid, and loads the config registers with their default values.
module rle_sprite_blit_decoder #(
  parameter int ADDR_BITS           = 20,
  parameter int MAX_BYTES_PER_PIXEL = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rsbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_code_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_write_valid,
  output logic [19:0]                      out_dest_addr,
  output logic [7:0]                       out_pixel_byte,
  output logic                             out_sprite_done,
  output logic                             out_format_error
);

  rsbd_pkg::cfg_t         cfg_r;
  logic                   in_fire;
  logic                   res_valid;
  rsbd_pkg::flags_t       res_flags;
  logic [ADDR_BITS-1:0]   res_addr;
  logic [7:0]             res_byte;
  logic [ADDR_BITS+19:0]  res_addr_ext;

  logic                   out_valid_r;
  rsbd_pkg::flags_t       out_flags_r;
  logic [19:0]            out_addr_r;
  logic [7:0]             out_byte_r;

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x        <= 8'd0;
      cfg_r.origin_y        <= 8'd0;
      cfg_r.run_width       <= 8'd1;
      cfg_r.run_height      <= 8'd1;
      cfg_r.bytes_per_pixel <= 3'd1;
      cfg_r.dest_pitch      <= 12'd400;
    end else if (cfg_we) begin
      case (cfg_index)
        rsbd_pkg::REG_ORIGIN_X:        cfg_r.origin_x        <= cfg_data[7:0];
        rsbd_pkg::REG_ORIGIN_Y:        cfg_r.origin_y        <= cfg_data[7:0];
        rsbd_pkg::REG_RUN_WIDTH:       cfg_r.run_width       <= cfg_data[7:0];
        rsbd_pkg::REG_RUN_HEIGHT:      cfg_r.run_height      <= cfg_data[7:0];
        rsbd_pkg::REG_BYTES_PER_PIXEL: cfg_r.bytes_per_pixel <= cfg_data[2:0];
        rsbd_pkg::REG_DEST_PITCH:      cfg_r.dest_pitch      <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Take a beat whenever the output register is empty or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  rsbd_decode #(
    .ADDR_BITS           (ADDR_BITS),
    .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step_en   (in_fire),
    .code_byte (in_code_byte),
    .res_valid (res_valid),
    .res_flags (res_flags),
    .res_addr  (res_addr),
    .res_byte  (res_byte)
  );

  // Fit the address to the 20-bit output field
  assign res_addr_ext = {20'd0, res_addr};

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_flags_r <= res_flags;
      out_addr_r  <= res_addr_ext[19:0];
      out_byte_r  <= res_byte;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_valid  = out_flags_r.write_valid;
  assign out_dest_addr    = out_addr_r;
  assign out_pixel_byte   = out_byte_r;
  assign out_sprite_done  = out_flags_r.sprite_done;
  assign out_format_error = out_flags_r.format_error;

endmodule
